// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on the rising clock edge, off while reset is high.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Assert that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPL(label, ante, cons, msg) \
   `ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

// ----- rtl/core/ipc_pkg.sv -----
// ----------------------------------------------------------------------------
// ipc_pkg
// Types and constants shared by the integer partition counter.
// ----------------------------------------------------------------------------
package ipc_pkg;

   localparam int NUM_W   = 8;   // width of the request value
   localparam int COUNT_W = 64;  // width of a table entry and of the count

   // Per-cycle commands from the sequencer to the table datapath.
   typedef struct packed {
      logic start;     // new request taken: clear the sticky saturation flag
      logic init_wr;   // write the seed value at address A
      logic init_one;  // seed value is one (else zero)
      logic step;      // issue one read-add-write step at addresses A and B
   } ipc_ctrl_type;

endpackage

// ----- rtl/core/integer_partition_counter.sv -----
// Sequence: seed entries 0 to n, then one table step for each pair
//   k <= r <= n, then drain and hand off the result. n of zero or above
//   MAX_N skips the table and answers a count of zero.
// Throughput: one request at a time; the single table adder (one step a cycle)
//   sets the rate. The next request is taken once the result is registered.
// Reset: synchronous, active high; clears sequencer, handshake, table flags.
// ----------------------------------------------------------------------------
// integer_partition_counter
// Partition count p(n) by running sums over a scratch table, iterated on one
// shared saturating adder.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module integer_partition_counter #(
   parameter int MAX_N = 255
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] number
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [63:0] count
   output logic [0:0]  rsp_tuser    // [0] saturated
);

   localparam int AW = $clog2(MAX_N + 1);

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_INIT  = 3'd1;
   localparam logic [2:0] S_STEP  = 3'd2;
   localparam logic [2:0] S_DRAIN = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]                  state_ff, state_in;
   logic [ipc_pkg::NUM_W-1:0]   n_ff, n_in;
   logic [ipc_pkg::NUM_W-1:0]   k_ff, k_in;   // part size
   logic [ipc_pkg::NUM_W-1:0]   r_ff, r_in;   // remainder
   logic                        ignore_ff, ignore_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [ipc_pkg::COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic                        rsp_sat_ff, rsp_sat_in;

   ipc_pkg::ipc_ctrl_type       ctrl;
   logic [ipc_pkg::NUM_W-1:0]   src_idx;
   logic [ipc_pkg::COUNT_W-1:0] last_sum;
   logic                        tbl_sat;
   logic                        req_fire;
   logic                        in_range;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign in_range   = (req_tdata != '0) && (32'(req_tdata) <= 32'(MAX_N));
   assign src_idx    = r_ff - k_ff;

   // Sequencer: seed the table, then sweep k = 1..n and r = k..n.
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      r_in         = r_ff;
      ignore_in    = ignore_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      rsp_sat_in   = rsp_sat_ff;
      ctrl         = '0;

      // drop the result once taken
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               ctrl.start = 1'b1;
               n_in       = req_tdata;
               r_in       = '0;
               k_in       = ipc_pkg::NUM_W'(1);
               ignore_in  = !in_range;
               state_in   = in_range ? S_INIT : S_DONE;
            end
         end
         S_INIT: begin
            // entry 0 seeds to one, the rest to zero
            ctrl.init_wr  = 1'b1;
            ctrl.init_one = (r_ff == '0);
            if (r_ff == n_ff) begin
               r_in     = ipc_pkg::NUM_W'(1);
               k_in     = ipc_pkg::NUM_W'(1);
               state_in = S_STEP;
            end else begin
               r_in = r_ff + ipc_pkg::NUM_W'(1);
            end
         end
         S_STEP: begin
            ctrl.step = 1'b1;
            if (r_ff == n_ff) begin
               if (k_ff == n_ff) begin
                  state_in = S_DRAIN;
               end else begin
                  k_in = k_ff + ipc_pkg::NUM_W'(1);
                  r_in = k_ff + ipc_pkg::NUM_W'(1);
               end
            end else begin
               r_in = r_ff + ipc_pkg::NUM_W'(1);
            end
         end
         S_DRAIN: begin
            // last add writes entry n this cycle
            state_in = S_DONE;
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = ignore_ff ? '0 : last_sum;
               rsp_sat_in   = ignore_ff ? 1'b0 : tbl_sat;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         n_ff         <= '0;
         k_ff         <= '0;
         r_ff         <= '0;
         ignore_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         k_ff         <= k_in;
         r_ff         <= r_in;
         ignore_ff    <= ignore_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_count_ff <= rsp_count_in;
      rsp_sat_ff   <= rsp_sat_in;
   end

   ipc_table #(
      .MAX_N (MAX_N)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .addr_a   (AW'(r_ff)),
      .addr_b   (AW'(src_idx)),
      .last_sum (last_sum),
      .sat      (tbl_sat)
   );

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_count_ff;
   assign rsp_tuser[0] = rsp_sat_ff;

   // sweep indices stay inside the triangle k <= r <= n
   `ASSERT_IMPL(a_step_bounds, state_ff == S_STEP,
      (k_ff != '0) && (k_ff <= r_ff) && (r_ff <= n_ff), "step index out of range")
   // seeding never runs past entry n
   `ASSERT_IMPL(a_init_bounds, state_ff == S_INIT, r_ff <= n_ff, "seed index past n")
   // the drain follows only the final step at k = r = n
   `ASSERT_IMPL(a_drain_last, state_ff == S_DRAIN,
      $past(state_ff) == S_STEP && k_ff == n_ff && r_ff == n_ff, "drain out of order")

endmodule

// ----- rtl/core/ipc_table.sv -----
// ----------------------------------------------------------------------------
// ipc_table
// Scratch table of running sums with one shared saturating 64-bit adder.
// ----------------------------------------------------------------------------
module ipc_table #(
   parameter int MAX_N = 255
) (
   input  logic                        clock,
   input  logic                        reset,
   input  ipc_pkg::ipc_ctrl_type       ctrl,
   input  logic [$clog2(MAX_N+1)-1:0]  addr_a,   // target entry r
   input  logic [$clog2(MAX_N+1)-1:0]  addr_b,   // source entry r - k
   output logic [ipc_pkg::COUNT_W-1:0] last_sum,
   output logic                        sat
);

   localparam int DEPTH = MAX_N + 1;
   localparam int AW    = $clog2(DEPTH);

   logic [ipc_pkg::COUNT_W-1:0] count_mem [DEPTH];

   logic [ipc_pkg::COUNT_W-1:0] rd_a_ff, rd_b_ff;
   logic [ipc_pkg::COUNT_W-1:0] last_sum_ff;
   logic [AW-1:0]               wr_addr_ff;
   logic                        step_v_ff, step_v_in;
   logic                        fwd_a_ff, fwd_a_in;
   logic                        fwd_b_ff, fwd_b_in;
   logic                        sat_ff, sat_in;

   logic [ipc_pkg::COUNT_W-1:0] op_a, op_b, sum;
   logic                        carry;

   // Take the operand from the write in flight when it targets the same entry.
   always_comb begin
      op_a = fwd_a_ff ? last_sum_ff : rd_a_ff;
      op_b = fwd_b_ff ? last_sum_ff : rd_b_ff;
      {carry, sum} = {1'b0, op_a} + {1'b0, op_b};
      if (carry) begin
         sum = '1;
      end
      step_v_in = ctrl.step;
      fwd_a_in  = step_v_ff && (wr_addr_ff == addr_a);
      fwd_b_in  = step_v_ff && (wr_addr_ff == addr_b);
      sat_in    = sat_ff;
      if (ctrl.start) begin
         sat_in = 1'b0;
      end else if (step_v_ff && carry) begin
         sat_in = 1'b1;
      end
   end

   // Memory: two registered read ports, one write port.
   always_ff @(posedge clock) begin
      rd_a_ff <= count_mem[addr_a];
      rd_b_ff <= count_mem[addr_b];
      if (step_v_ff) begin
         count_mem[wr_addr_ff] <= sum;
      end else if (ctrl.init_wr) begin
         count_mem[addr_a] <= ctrl.init_one ? ipc_pkg::COUNT_W'(1) : '0;
      end
   end

   always_ff @(posedge clock) begin
      wr_addr_ff <= addr_a;
      if (step_v_ff) begin
         last_sum_ff <= sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_v_ff <= 1'b0;
         fwd_a_ff  <= 1'b0;
         fwd_b_ff  <= 1'b0;
         sat_ff    <= 1'b0;
      end else begin
         step_v_ff <= step_v_in;
         fwd_a_ff  <= fwd_a_in;
         fwd_b_ff  <= fwd_b_in;
         sat_ff    <= sat_in;
      end
   end

   assign last_sum = last_sum_ff;
   assign sat      = sat_ff;

endmodule

// ----- dv/integer_partition_counter_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_partition_counter_tb
// Self-checking bench for the partition counter. A directed table covers the
// smallest values, a few known counts and the widest n; random requests follow.
// Each request is predicted with a local running-sum table. Both stream sides
// idle at random, and each result is compared with the oldest pending count.
// ----------------------------------------------------------------------------
module integer_partition_counter_tb;

   localparam int MAX_N        = 255;
   localparam int RANDOM_ITEMS = 100;
   localparam int WIDE_CAP     = 6;         // cap on random requests with n of 128 or more
   localparam int MID_CAP      = 12;        // cap on random requests with n from 41 to 127
   localparam int CYCLE_LIMIT  = 2_000_000; // well above the slowest legal run
   localparam int DRAIN_CYCLES = 16;        // idle time after the last answer

   logic                        clock;
   logic                        reset;
   logic                        req_tvalid;
   logic                        req_tready;
   logic [ipc_pkg::NUM_W-1:0]   req_tdata;    // [7:0] number
   logic                        rsp_tvalid;
   logic                        rsp_tready;
   logic [ipc_pkg::COUNT_W-1:0] rsp_tdata;    // [63:0] count
   logic [0:0]                  rsp_tuser;    // [0] saturated

   // One expected result: the count and its saturation flag.
   typedef struct packed {
      logic [ipc_pkg::COUNT_W-1:0] count;
      logic                        saturated;
   } partition_result_type;

   // One row of the directed table. Rows with known_count set carry a
   // hand-typed answer; the others are predicted.
   typedef struct packed {
      logic [ipc_pkg::NUM_W-1:0]   number;
      logic                        known_count;
      logic [ipc_pkg::COUNT_W-1:0] count;
      logic                        saturated;
   } directed_row_type;

   localparam int DIRECTED_ROWS = 17;
   directed_row_type directed_table [DIRECTED_ROWS] = '{
      '{8'd0,   1'b1, 64'd0,   1'b0},   // zero gives no partitions
      '{8'd1,   1'b1, 64'd1,   1'b0},   // smallest nonzero value
      '{8'd2,   1'b1, 64'd2,   1'b0},
      '{8'd3,   1'b1, 64'd3,   1'b0},
      '{8'd4,   1'b1, 64'd5,   1'b0},
      '{8'd5,   1'b1, 64'd7,   1'b0},
      '{8'd6,   1'b1, 64'd11,  1'b0},
      '{8'd10,  1'b1, 64'd42,  1'b0},
      '{8'd0,   1'b1, 64'd0,   1'b0},   // zero right after real work
      '{8'd255, 1'b0, 64'd0,   1'b0},   // widest value, full table
      '{8'd1,   1'b1, 64'd1,   1'b0},   // small n over a dirty table
      '{8'd20,  1'b1, 64'd627, 1'b0},
      '{8'd128, 1'b0, 64'd0,   1'b0},   // top bit alone
      '{8'd127, 1'b0, 64'd0,   1'b0},   // all low bits set
      '{8'd64,  1'b0, 64'd0,   1'b0},
      '{8'd100, 1'b0, 64'd0,   1'b0},
      '{8'd0,   1'b1, 64'd0,   1'b0}
   };

   // Local copy of the scratch table used by the predictor.
   logic [ipc_pkg::COUNT_W-1:0] partition_ways [0:MAX_N];

   partition_result_type pending_counts[$];
   int                   error_count;
   int                   cycle_count;
   bit                   requests_done;

   integer_partition_counter #(
      .MAX_N (MAX_N)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hold reset high at the start, then release it, once.
   initial begin
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // Abort a hung run.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Compute p(n) the way the block does: seed the table with ways[0] = 1 and
   // zeros above, then add ways[r-k] into ways[r] for every part size k and
   // every remainder r >= k, saturating each sum at the 64-bit ceiling.
   function automatic partition_result_type count_partitions(
      input logic [ipc_pkg::NUM_W-1:0] number);
      partition_result_type      res;
      logic [ipc_pkg::COUNT_W:0] sum;
      int                        n;
      n = int'(number);
      res.count     = '0;
      res.saturated = 1'b0;
      if (n >= 1 && n <= MAX_N) begin
         partition_ways[0] = 64'd1;
         for (int r = 1; r <= n; r++) partition_ways[r] = '0;
         for (int k = 1; k <= n; k++) begin
            for (int r = k; r <= n; r++) begin
               sum = {1'b0, partition_ways[r]} + {1'b0, partition_ways[r-k]};
               if (sum[ipc_pkg::COUNT_W]) begin
                  partition_ways[r] = '1;
                  res.saturated     = 1'b1;
               end else begin
                  partition_ways[r] = sum[ipc_pkg::COUNT_W-1:0];
               end
            end
         end
         res.count = partition_ways[n];
      end
      return res;
   endfunction

   // Idle draw shared by both sides: in burst mode no gap at all, otherwise a
   // random gap. Burst mode flips now and then so both regimes show up.
   function automatic int draw_gap(ref bit burst);
      if ($urandom_range(0, 15) == 0) burst = ~burst;
      return burst ? 0 : $urandom_range(0, 6);
   endfunction

   // Request side: walk the directed table, then random requests.
   initial begin : request_source
      partition_result_type       expected;
      logic [ipc_pkg::NUM_W-1:0]  number;
      int                         gap;
      int                         sel;
      int                         wide_left;
      int                         mid_left;
      bit                         burst;
      wide_left     = WIDE_CAP;
      mid_left      = MID_CAP;
      burst         = 1'b0;
      requests_done = 1'b0;
      req_tvalid   <= 1'b0;
      req_tdata    <= '0;
      wait (!reset);
      @(posedge clock);
      for (int i = 0; i < DIRECTED_ROWS + RANDOM_ITEMS; i++) begin
         if (i < DIRECTED_ROWS) begin
            number = directed_table[i].number;
         end else begin
            // Keep most requests small; only a handful pay the long table walk.
            sel = $urandom_range(0, 99);
            if (sel >= 95 && wide_left > 0) begin
               number = ipc_pkg::NUM_W'($urandom_range(128, MAX_N));
               wide_left--;
            end else if (sel >= 80 && mid_left > 0) begin
               number = ipc_pkg::NUM_W'($urandom_range(41, 127));
               mid_left--;
            end else begin
               number = ipc_pkg::NUM_W'($urandom_range(0, 40));
            end
         end
         // Drop valid only when a gap is due, so a held valid is never
         // lowered and raised in the same step.
         gap = draw_gap(burst);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= number;
         do @(posedge clock); while (!req_tready);
         // Request taken at this edge: queue its answer.
         expected = count_partitions(number);
         if (i < DIRECTED_ROWS && directed_table[i].known_count) begin
            expected.count     = directed_table[i].count;
            expected.saturated = directed_table[i].saturated;
         end
         pending_counts.push_back(expected);
      end
      req_tvalid    <= 1'b0;
      requests_done  = 1'b1;
   end

   // Result side: stall at random, compare every accepted result.
   initial begin : result_sink
      partition_result_type  expected;
      int                    stall;
      bit                    burst;
      burst       = 1'b0;
      rsp_tready <= 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         stall = draw_gap(burst);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         if (pending_counts.size() == 0) begin
            $display("%0t: result with no request pending: count %0d saturated %0d",
                     $time, rsp_tdata, rsp_tuser[0]);
            error_count++;
         end else begin
            expected = pending_counts.pop_front();
            if (rsp_tdata !== expected.count) begin
               $display("%0t: count mismatch: expected %0d, actual %0d",
                        $time, expected.count, rsp_tdata);
               error_count++;
            end
            if (rsp_tuser[0] !== expected.saturated) begin
               $display("%0t: saturated mismatch: expected %0d, actual %0d",
                        $time, expected.saturated, rsp_tuser[0]);
               error_count++;
            end
         end
      end
   end

   // End of run: all requests in, all answers back, then a short drain to
   // catch stray results.
   initial begin : run_control
      error_count = 0;
      wait (requests_done);
      while (pending_counts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
